// ===== design/dmoc_pkg.sv =====
// Shared constants, codes and controller/datapath types of the operand cache.
package dmoc_pkg;

   localparam int NUM_LINES  = 512;
   localparam int LINE_WORDS = 8;
   localparam int IDX_W      = $clog2(NUM_LINES);
   localparam int WORD_W     = $clog2(LINE_WORDS);
   localparam int SLOT_W     = IDX_W + WORD_W;
   localparam int TAG_W      = 19;
   localparam int ADDR_W     = 29;
   localparam int DATA_W     = 32;
   localparam int PADDR_W    = 14;
   localparam int FLAG_W     = 2;

   typedef enum logic [3:0] {
      OP_READ      = 4'd0,
      OP_WRITE     = 4'd1,
      OP_PREFETCH  = 4'd2,
      OP_INVALIDATE = 4'd3,
      OP_PURGE     = 4'd4,
      OP_WRITEBACK = 4'd5,
      OP_FILL      = 4'd6,
      OP_TAGREAD   = 4'd7,
      OP_TAGWRITE  = 4'd8,
      OP_DATAREAD  = 4'd9,
      OP_DATAWRITE = 4'd10,
      OP_INVALL    = 4'd11
   } op_type;

   typedef enum logic [2:0] {
      KIND_READ   = 3'd0,
      KIND_DONE   = 3'd1,
      KIND_BEAT   = 3'd2,
      KIND_FILL   = 3'd3,
      KIND_REJECT = 3'd4
   } kind_type;

   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;

   typedef enum logic [2:0] {
      DP_NONE,
      DP_DECIDE,
      DP_BEAT,
      DP_POST,
      DP_CLEAR,
      DP_INVALL,
      DP_DONE
   } action_type;

   typedef enum logic [2:0] {
      RT_IDLE,
      RT_READ,
      RT_SEND,
      RT_POST,
      RT_INVALL
   } route_type;

   typedef struct packed {
      action_type action;
      logic       send_addr;
      logic       req_ready;
   } cmd_type;

   typedef struct packed {
      logic      out_free;
      route_type route;
      logic      beat_last;
      logic      sweep_last;
   } status_type;

endpackage

// ===== design/dmoc_if.sv =====
// Item channel interfaces for requests and results.
interface dmoc_req_if;
   import dmoc_pkg::*;
   logic                valid;
   logic                ready;
   logic [3:0]          op;
   logic [ADDR_W-1:0]   address;
   logic [1:0]          access_size;
   logic [DATA_W-1:0]   wdata;
   modport source (output valid, op, address, access_size, wdata, input ready);
   modport sink (input valid, op, address, access_size, wdata, output ready);
endinterface

interface dmoc_rsp_if;
   import dmoc_pkg::*;
   logic                valid;
   logic                ready;
   logic [2:0]          kind;
   logic [ADDR_W-1:0]   bus_address;
   logic [DATA_W-1:0]   rdata;
   logic                last;
   modport source (output valid, kind, bus_address, rdata, last, input ready);
   modport sink (input valid, kind, bus_address, rdata, last, output ready);
endinterface

// ===== design/dmoc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dmoc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// ===== design/dmoc_ctrl.sv =====
// Sequencing state machine of the operand cache.
module dmoc_ctrl
   import dmoc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type status,
   output cmd_type    cmd
);
   typedef enum logic [8:0] {
      S_CLEAR    = 9'b000000001,
      S_IDLE     = 9'b000000010,
      S_READ     = 9'b000000100,
      S_DEC      = 9'b000001000,
      S_SEND_RD  = 9'b000010000,
      S_SEND_OUT = 9'b000100000,
      S_POST     = 9'b001000000,
      S_INVALL   = 9'b010000000,
      S_DONE     = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in      = state_ff;
      cmd.action    = DP_NONE;
      cmd.send_addr = 1'b0;
      cmd.req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.action = DP_CLEAR;
            if (status.sweep_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            cmd.req_ready = 1'b1;
            if (req_valid) state_in = S_READ;
         end
         S_READ: state_in = S_DEC;
         S_DEC: begin
            cmd.action = DP_DECIDE;
            if (status.out_free) begin
               case (status.route)
                  RT_READ:   state_in = S_READ;
                  RT_SEND:   state_in = S_SEND_RD;
                  RT_POST:   state_in = S_POST;
                  RT_INVALL: state_in = S_INVALL;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_SEND_RD: begin
            cmd.send_addr = 1'b1;
            state_in      = S_SEND_OUT;
         end
         S_SEND_OUT: begin
            cmd.send_addr = 1'b1;
            cmd.action    = DP_BEAT;
            if (status.out_free) state_in = status.beat_last ? S_POST : S_SEND_RD;
         end
         S_POST: begin
            cmd.action = DP_POST;
            if (status.out_free) state_in = S_IDLE;
         end
         S_INVALL: begin
            cmd.action = DP_INVALL;
            if (status.sweep_last) state_in = S_DONE;
         end
         S_DONE: begin
            cmd.action = DP_DONE;
            if (status.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== design/dmoc_dp.sv =====
// Datapath of the operand cache: arrays, held item, pending fill and result register.
module dmoc_dp
   import dmoc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic              req_valid,
   input  logic [3:0]        req_op,
   input  logic [ADDR_W-1:0] req_address,
   input  logic [1:0]        req_access_size,
   input  logic [DATA_W-1:0] req_wdata,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_kind,
   output logic [ADDR_W-1:0] rsp_bus_address,
   output logic [DATA_W-1:0] rsp_rdata,
   output logic              rsp_last
);
   logic [3:0]         op_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [1:0]         size_ff;
   logic [DATA_W-1:0]  wdata_ff;
   logic               serve_ff, hit_ff, dirty_ff;
   logic [WORD_W-1:0]  beat_ff;
   logic [IDX_W-1:0]   sweep_ff;
   logic [ADDR_W-1:0]  vbase_ff;
   logic               pend_ff;
   logic [PADDR_W-1:0] pend_addr_ff;
   logic [1:0]         pend_size_ff, pend_op_ff;
   logic [DATA_W-1:0]  pend_wdata_ff;
   logic [WORD_W-1:0]  fill_cnt_ff;
   logic               rsp_valid_ff, rsp_last_ff;
   logic [2:0]         rsp_kind_ff;
   logic [ADDR_W-1:0]  rsp_bus_ff;
   logic [DATA_W-1:0]  rsp_data_ff;

   logic               tag_we, flag_we, data_we;
   logic [IDX_W-1:0]   tag_waddr, flag_waddr, idx, pidx;
   logic [TAG_W-1:0]   tag_wdata, tag_q, addr_tag;
   logic [FLAG_W-1:0]  flag_wdata, flag_q;
   logic [SLOT_W-1:0]  data_waddr, data_raddr;
   logic [DATA_W-1:0]  data_wdata, data_q, rd_val, merged;
   logic               hit, vld, drt, free, accept;
   logic               emit, emit_last;
   kind_type           emit_kind;
   logic [ADDR_W-1:0]  emit_bus;
   logic [DATA_W-1:0]  emit_data;
   logic               do_fill_last, do_fill_step, do_capture_hitinfo;
   route_type          route;

   dmoc_ram #(.WIDTH(TAG_W), .DEPTH(NUM_LINES)) u_tag_ram (
      .clock(clock), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
      .raddr(idx), .rdata(tag_q));

   dmoc_ram #(.WIDTH(FLAG_W), .DEPTH(NUM_LINES)) u_flag_ram (
      .clock(clock), .we(flag_we), .waddr(flag_waddr), .wdata(flag_wdata),
      .raddr(idx), .rdata(flag_q));

   dmoc_ram #(.WIDTH(DATA_W), .DEPTH(NUM_LINES * LINE_WORDS)) u_data_ram (
      .clock(clock), .we(data_we), .waddr(data_waddr), .wdata(data_wdata),
      .raddr(data_raddr), .rdata(data_q));

   assign idx        = addr_ff[5 +: IDX_W];
   assign pidx       = pend_addr_ff[5 +: IDX_W];
   assign addr_tag   = addr_ff[ADDR_W-1:10];
   assign data_raddr = cmd.send_addr ? {idx, beat_ff} : {idx, addr_ff[4:2]};
   assign vld        = flag_q[0];
   assign drt        = flag_q[1];
   assign hit        = vld && (tag_q == addr_tag);
   assign free       = !rsp_valid_ff || rsp_ready;
   assign accept     = cmd.req_ready && req_valid;

   always_comb begin
      rd_val = data_q;
      merged = wdata_ff;
      case (size_ff)
         SIZE_BYTE: begin
            rd_val = {{24{data_q[8*addr_ff[1:0] + 7]}}, data_q[8*addr_ff[1:0] +: 8]};
            merged = data_q;
            merged[8*addr_ff[1:0] +: 8] = wdata_ff[7:0];
         end
         SIZE_HALF: begin
            rd_val = {{16{data_q[16*addr_ff[1] + 15]}}, data_q[16*addr_ff[1] +: 16]};
            merged = data_q;
            merged[16*addr_ff[1] +: 16] = wdata_ff[15:0];
         end
         default: begin
            rd_val = data_q;
            merged = wdata_ff;
         end
      endcase
   end

   always_comb begin
      route = RT_IDLE;
      if (op_ff == OP_FILL) begin
         route = (pend_ff && fill_cnt_ff == WORD_W'(LINE_WORDS - 1)) ? RT_READ : RT_IDLE;
      end else if (serve_ff) begin
         route = RT_IDLE;
      end else if (pend_ff || op_ff > OP_INVALL) begin
         route = RT_IDLE;
      end else begin
         unique case (op_ff)
            OP_READ, OP_WRITE, OP_PREFETCH:
               route = hit ? RT_IDLE : ((vld && drt) ? RT_SEND : RT_POST);
            OP_INVALIDATE: route = RT_POST;
            OP_PURGE, OP_WRITEBACK: route = (hit && drt) ? RT_SEND : RT_POST;
            OP_TAGWRITE: route = (!addr_ff[3] && vld && drt) ? RT_SEND : RT_POST;
            OP_INVALL: route = RT_INVALL;
            default: route = RT_IDLE;
         endcase
      end
   end

   assign status.out_free   = free;
   assign status.route      = route;
   assign status.beat_last  = (beat_ff == WORD_W'(LINE_WORDS - 1));
   assign status.sweep_last = (sweep_ff == {IDX_W{1'b1}});

   always_comb begin
      tag_we = 1'b0; tag_waddr = idx; tag_wdata = addr_tag;
      flag_we = 1'b0; flag_waddr = idx; flag_wdata = '0;
      data_we = 1'b0; data_waddr = {idx, addr_ff[4:2]}; data_wdata = merged;
      emit = 1'b0; emit_kind = KIND_DONE; emit_bus = '0; emit_data = '0; emit_last = 1'b1;
      do_fill_last = 1'b0; do_fill_step = 1'b0;
      do_capture_hitinfo = 1'b0;
      case (cmd.action)
         DP_CLEAR: begin
            tag_we = 1'b1; tag_waddr = sweep_ff; tag_wdata = '0;
            flag_we = 1'b1; flag_waddr = sweep_ff;
         end
         DP_INVALL: begin
            flag_we = 1'b1; flag_waddr = sweep_ff;
         end
         DP_DONE: emit = free;
         DP_BEAT: begin
            emit = free; emit_kind = KIND_BEAT; emit_bus = vbase_ff;
            emit_data = data_q; emit_last = 1'b0;
         end
         DP_DECIDE: if (free) begin
            do_capture_hitinfo = 1'b1;
            if (op_ff == OP_FILL) begin
               if (!pend_ff) begin
                  emit = 1'b1; emit_kind = KIND_REJECT;
               end else begin
                  data_we = 1'b1; data_waddr = {pidx, fill_cnt_ff}; data_wdata = wdata_ff;
                  if (fill_cnt_ff == WORD_W'(LINE_WORDS - 1)) begin
                     do_fill_last = 1'b1;
                     flag_we = 1'b1; flag_waddr = pidx; flag_wdata = 2'b01;
                  end else begin
                     do_fill_step = 1'b1;
                  end
               end
            end else if (!serve_ff && (pend_ff || op_ff > OP_INVALL)) begin
               emit = 1'b1; emit_kind = KIND_REJECT;
            end else if (serve_ff || ((op_ff == OP_READ || op_ff == OP_WRITE ||
                                       op_ff == OP_PREFETCH) && hit)) begin
               emit = 1'b1;
               if (op_ff == OP_READ) begin
                  emit_kind = KIND_READ; emit_data = rd_val;
               end else if (op_ff == OP_WRITE) begin
                  data_we = 1'b1;
                  flag_we = 1'b1; flag_wdata = 2'b11;
               end
            end else begin
               unique case (op_ff)
                  OP_TAGREAD: begin
                     emit = 1'b1; emit_kind = KIND_READ;
                     emit_data = {3'b000, tag_q, 8'h00, drt, vld};
                  end
                  OP_DATAREAD: begin
                     emit = 1'b1; emit_kind = KIND_READ; emit_data = data_q;
                  end
                  OP_DATAWRITE: begin
                     emit = 1'b1; data_we = 1'b1; data_wdata = wdata_ff;
                  end
                  default: emit = 1'b0;
               endcase
            end
         end
         DP_POST: if (free) begin
            emit = 1'b1;
            unique case (op_ff)
               OP_READ, OP_WRITE, OP_PREFETCH: begin
                  tag_we = 1'b1;
                  flag_we = 1'b1; flag_wdata = 2'b00;
                  emit_kind = KIND_FILL; emit_bus = {addr_ff[ADDR_W-1:5], 5'b00000};
               end
               OP_INVALIDATE, OP_PURGE: begin
                  flag_we = hit_ff; flag_wdata = {dirty_ff, 1'b0};
               end
               OP_WRITEBACK: begin
                  flag_we = hit_ff && dirty_ff; flag_wdata = 2'b01;
               end
               OP_TAGWRITE: begin
                  tag_we = !addr_ff[3]; tag_wdata = wdata_ff[ADDR_W-1:10];
                  flag_we = !addr_ff[3]; flag_wdata = wdata_ff[1:0];
               end
               default: emit = 1'b1;
            endcase
         end
         default: emit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_op;
         addr_ff  <= req_address;
         size_ff  <= req_access_size;
         wdata_ff <= req_wdata;
      end else if (do_fill_last) begin
         op_ff    <= {2'b00, pend_op_ff};
         addr_ff  <= {(ADDR_W - PADDR_W)'(0), pend_addr_ff};
         size_ff  <= pend_size_ff;
         wdata_ff <= pend_wdata_ff;
      end
      if (do_capture_hitinfo) begin
         hit_ff   <= hit;
         dirty_ff <= drt;
         vbase_ff <= {tag_q, idx[4:0], 5'b00000};
      end
      if (cmd.action == DP_POST && free && !pend_ff) begin
         pend_addr_ff  <= addr_ff[PADDR_W-1:0];
         pend_size_ff  <= size_ff;
         pend_op_ff    <= op_ff[1:0];
         pend_wdata_ff <= wdata_ff;
      end
      if (emit) begin
         rsp_kind_ff <= emit_kind;
         rsp_bus_ff  <= emit_bus;
         rsp_data_ff <= emit_data;
         rsp_last_ff <= emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         serve_ff     <= 1'b0;
         beat_ff      <= '0;
         sweep_ff     <= '0;
         pend_ff      <= 1'b0;
         fill_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            serve_ff <= 1'b0;
         end else if (do_fill_last) begin
            serve_ff <= 1'b1;
         end
         if (cmd.action == DP_BEAT && free) beat_ff <= beat_ff + 1'b1;
         if (cmd.action == DP_CLEAR || cmd.action == DP_INVALL) sweep_ff <= sweep_ff + 1'b1;
         if (do_fill_step) fill_cnt_ff <= fill_cnt_ff + 1'b1;
         if (do_fill_last) begin
            fill_cnt_ff <= '0;
            pend_ff     <= 1'b0;
         end
         if (cmd.action == DP_POST && free &&
             (op_ff == OP_READ || op_ff == OP_WRITE || op_ff == OP_PREFETCH)) begin
            pend_ff     <= 1'b1;
            fill_cnt_ff <= '0;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_bus_address = rsp_bus_ff;
   assign rsp_rdata       = rsp_data_ff;
   assign rsp_last        = rsp_last_ff;
endmodule

// ===== design/direct_mapped_copyback_operand_cache_top.sv =====
// Top level of the direct-mapped copy-back operand cache.
//
// Requests enter on req_if (op, address, access_size, wdata) and results leave on
// rsp_if (kind, bus_address, rdata, last), both valid/ready item channels. Each
// request, save a fill beat before the last, gives one or more result items;
// the final one carries last. One request is worked on at a time: a request is
// taken only while the block is idle. A hit, tag read, data read or data write
// reads the arrays in the read state, registers its result in the decide state
// and goes back to idle. Each writeback beat passes a read state and a send
// state, since every beat waits for the registered read of the data array. A
// miss stores the access and answers with a fill request; the eight fill beats
// then enter as request items and the eighth completes the held access. Other
// requests during a fill are rejected. Invalidate-all sweeps the flag array, one
// line a cycle. After reset a clearing pass zeroes the tag and flag arrays; no
// request is taken until it ends. A result waits in the output register while
// rsp_if.ready is low; the block then holds any further result until the slot frees.
module direct_mapped_copyback_operand_cache_top
   import dmoc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   dmoc_req_if.sink   req_if,
   dmoc_rsp_if.source rsp_if
);
   cmd_type    cmd;
   status_type status;

   dmoc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_if.valid),
      .status(status), .cmd(cmd));

   dmoc_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_valid(req_if.valid), .req_op(req_if.op), .req_address(req_if.address),
      .req_access_size(req_if.access_size), .req_wdata(req_if.wdata),
      .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready), .rsp_kind(rsp_if.kind),
      .rsp_bus_address(rsp_if.bus_address), .rsp_rdata(rsp_if.rdata),
      .rsp_last(rsp_if.last));

   assign req_if.ready = cmd.req_ready;
endmodule

// ===== sim/tb_direct_mapped_copyback_operand_cache_top.sv =====
// Self-checking testbench of the direct-mapped copy-back operand cache.
module tb_direct_mapped_copyback_operand_cache_top;
   import dmoc_pkg::*;

   localparam logic [3:0] OP_RSVD_LO = 4'd12;
   localparam logic [3:0] OP_RSVD_HI = 4'd15;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int RANDOM_ITEMS = 283;
   localparam int DRAIN_CYCLES = 700;

   typedef struct {
      logic [3:0]        op;
      logic [ADDR_W-1:0] addr;
      logic [1:0]        size;
      logic [DATA_W-1:0] wd;
      bit                typed;
      logic [2:0]        t_kind;
      logic [DATA_W-1:0] t_rdata;
   } cache_item;

   typedef struct {
      logic [2:0]        kind;
      logic [ADDR_W-1:0] bus;
      logic [DATA_W-1:0] rdata;
      bit                last;
   } cache_result;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dmoc_req_if req_if ();
   dmoc_rsp_if rsp_if ();

   direct_mapped_copyback_operand_cache_top DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the cache
   logic [TAG_W-1:0]  line_tag [NUM_LINES];
   bit                line_valid [NUM_LINES];
   bit                line_dirty [NUM_LINES];
   logic [DATA_W-1:0] line_word [NUM_LINES*LINE_WORDS];
   bit                word_known [NUM_LINES*LINE_WORDS];
   bit                fill_busy;
   logic [13:0]       held_addr;
   logic [1:0]        held_size;
   logic [1:0]        held_op;
   logic [DATA_W-1:0] held_wd;
   logic [2:0]        beats_in;

   cache_result expected_q[$];
   cache_result fresh_q[$];

   int errors = 0;
   int cycles = 0;
   int accepted = 0;
   int results_seen = 0;
   int burst_left = 0;
   bit long_hold_go = 0;

   logic [TAG_W-1:0] tag_pool [4];
   logic [8:0]       idx_pool [8];

   task automatic report(input string what, input cache_result got, input cache_result want);
      errors++;
      $display("MISMATCH %s: got kind %0d bus %h data %h last %0d, want kind %0d bus %h data %h last %0d",
               what, got.kind, got.bus, got.rdata, got.last,
               want.kind, want.bus, want.rdata, want.last);
   endtask

   function automatic void add_result(input logic [2:0] k, input logic [ADDR_W-1:0] b,
                                      input logic [DATA_W-1:0] d);
      cache_result r;
      r.kind = k; r.bus = b; r.rdata = d; r.last = 0;
      fresh_q.push_back(r);
   endfunction

   function automatic void emit_line(input logic [8:0] idx);
      for (int k = 0; k < LINE_WORDS; k++)
         add_result(KIND_BEAT, {line_tag[idx], idx[4:0], 5'd0}, line_word[{idx, k[2:0]}]);
   endfunction

   function automatic bit line_hit(input logic [ADDR_W-1:0] a);
      return line_valid[a[13:5]] && line_tag[a[13:5]] == a[28:10];
   endfunction

   function automatic void serve_access(input logic [1:0] op, input logic [ADDR_W-1:0] a,
                                        input logic [1:0] sz, input logic [DATA_W-1:0] wd);
      logic [11:0] s;
      logic [DATA_W-1:0] w, v, m;
      int sh;
      s = {a[13:5], a[4:2]};
      w = line_word[s];
      if (op == 2'(OP_READ)) begin
         if (sz == SIZE_BYTE) begin
            sh = a[1:0] * 8;
            v = {{24{w[sh+7]}}, w[sh +: 8]};
         end else if (sz == SIZE_HALF) begin
            sh = a[1] * 16;
            v = {{16{w[sh+15]}}, w[sh +: 16]};
         end else begin
            v = w;
         end
         add_result(KIND_READ, '0, v);
      end else if (op == 2'(OP_WRITE)) begin
         if (sz == SIZE_BYTE) begin
            sh = a[1:0] * 8; m = 32'hFF << sh;
         end else if (sz == SIZE_HALF) begin
            sh = a[1] * 16; m = 32'hFFFF << sh;
         end else begin
            sh = 0; m = '1;
         end
         line_word[s] = (w & ~m) | ((wd << sh) & m);
         word_known[s] = 1;
         line_dirty[a[13:5]] = 1;
         add_result(KIND_DONE, '0, '0);
      end else begin
         add_result(KIND_DONE, '0, '0);
      end
   endfunction

   function automatic void predict_cache(input cache_item it);
      logic [8:0] idx, pidx;
      logic [1:0] sz;
      logic [ADDR_W-1:0] a;
      a = it.addr;
      idx = a[13:5];
      sz = (it.size == 2'd3) ? 2'd2 : it.size;
      fresh_q.delete();
      if (it.op == OP_FILL) begin
         if (!fill_busy) begin
            add_result(KIND_REJECT, '0, '0);
         end else begin
            pidx = held_addr[13:5];
            line_word[{pidx, beats_in}] = it.wd;
            word_known[{pidx, beats_in}] = 1;
            if (beats_in == 3'd7) begin
               beats_in = 0;
               fill_busy = 0;
               line_valid[pidx] = 1;
               serve_access(held_op, {15'd0, held_addr}, held_size, held_wd);
            end else begin
               beats_in++;
            end
         end
      end else if (fill_busy || it.op > OP_INVALL) begin
         add_result(KIND_REJECT, '0, '0);
      end else begin
         case (it.op)
            OP_READ, OP_WRITE, OP_PREFETCH: begin
               if (line_hit(a)) begin
                  serve_access(it.op[1:0], a, sz, it.wd);
               end else begin
                  if (line_valid[idx] && line_dirty[idx]) emit_line(idx);
                  line_tag[idx] = a[28:10];
                  line_valid[idx] = 0;
                  line_dirty[idx] = 0;
                  add_result(KIND_FILL, {a[28:5], 5'd0}, '0);
                  fill_busy = 1;
                  beats_in = 0;
                  held_addr = a[13:0];
                  held_size = sz;
                  held_op = it.op[1:0];
                  held_wd = it.wd;
               end
            end
            OP_INVALIDATE: begin
               if (line_hit(a)) line_valid[idx] = 0;
               add_result(KIND_DONE, '0, '0);
            end
            OP_PURGE: begin
               if (line_hit(a)) begin
                  if (line_dirty[idx]) emit_line(idx);
                  line_valid[idx] = 0;
               end
               add_result(KIND_DONE, '0, '0);
            end
            OP_WRITEBACK: begin
               if (line_hit(a) && line_dirty[idx]) begin
                  emit_line(idx);
                  line_dirty[idx] = 0;
               end
               add_result(KIND_DONE, '0, '0);
            end
            OP_TAGREAD:
               add_result(KIND_READ, '0,
                          {3'd0, line_tag[idx], 8'd0, line_dirty[idx], line_valid[idx]});
            OP_TAGWRITE: begin
               if (!a[3]) begin
                  if (line_valid[idx] && line_dirty[idx]) emit_line(idx);
                  line_tag[idx] = it.wd[28:10];
                  line_valid[idx] = it.wd[0];
                  line_dirty[idx] = it.wd[1];
               end
               add_result(KIND_DONE, '0, '0);
            end
            OP_DATAREAD: add_result(KIND_READ, '0, line_word[{idx, a[4:2]}]);
            OP_DATAWRITE: begin
               line_word[{idx, a[4:2]}] = it.wd;
               word_known[{idx, a[4:2]}] = 1;
               add_result(KIND_DONE, '0, '0);
            end
            default: begin
               for (int k = 0; k < NUM_LINES; k++) begin
                  line_valid[k] = 0;
                  line_dirty[k] = 0;
               end
               add_result(KIND_DONE, '0, '0);
            end
         endcase
      end
      fresh_q[fresh_q.size()-1].last = 1;
      if (it.typed) begin
         fresh_q[fresh_q.size()-1].kind = it.t_kind;
         fresh_q[fresh_q.size()-1].rdata = it.t_rdata;
      end
      foreach (fresh_q[i]) expected_q.push_back(fresh_q[i]);
   endfunction

   // first word an item would read before it was ever written, or -1
   function automatic int unknown_word(input cache_item it);
      logic [8:0] idx;
      bit hit;
      bit need_word, need_line;
      idx = it.addr[13:5];
      hit = line_hit(it.addr);
      need_word = 0;
      need_line = 0;
      if (fill_busy || it.op > OP_INVALL || it.op == OP_FILL) return -1;
      case (it.op)
         OP_READ:     if (hit) need_word = 1; else need_line = line_valid[idx] && line_dirty[idx];
         OP_WRITE:    if (hit) need_word = (it.size != 2'd2 && it.size != 2'd3);
                      else need_line = line_valid[idx] && line_dirty[idx];
         OP_PREFETCH: if (!hit) need_line = line_valid[idx] && line_dirty[idx];
         OP_PURGE, OP_WRITEBACK: need_line = hit && line_dirty[idx];
         OP_TAGWRITE: need_line = !it.addr[3] && line_valid[idx] && line_dirty[idx];
         OP_DATAREAD: need_word = 1;
         default: ;
      endcase
      if (need_word && !word_known[{idx, it.addr[4:2]}]) return {idx, it.addr[4:2]};
      if (need_line)
         for (int k = 0; k < LINE_WORDS; k++)
            if (!word_known[{idx, k[2:0]}]) return {idx, k[2:0]};
      return -1;
   endfunction

   function automatic cache_item row(input logic [3:0] op, input logic [ADDR_W-1:0] a,
                                     input logic [1:0] sz, input logic [DATA_W-1:0] wd,
                                     input bit typed = 0, input logic [2:0] k = KIND_DONE,
                                     input logic [DATA_W-1:0] d = '0);
      cache_item it;
      it.op = op; it.addr = a; it.size = sz; it.wd = wd;
      it.typed = typed; it.t_kind = k; it.t_rdata = d;
      return it;
   endfunction

   function automatic logic [ADDR_W-1:0] pick_address();
      logic [8:0] ix;
      if ($urandom_range(0, 4) == 0) return ADDR_W'($urandom());
      ix = idx_pool[$urandom_range(0, 7)];
      return {tag_pool[$urandom_range(0, 3)], ix[4:0], 5'($urandom())};
   endfunction

   function automatic cache_item random_item();
      cache_item it;
      int r, slot;
      it = row(OP_READ, pick_address(), 2'($urandom()), $urandom());
      r = $urandom_range(0, 99);
      if (fill_busy && r < 85) it.op = OP_FILL;
      else if (r < 25) it.op = OP_READ;
      else if (r < 50) it.op = OP_WRITE;
      else if (r < 55) it.op = OP_PREFETCH;
      else if (r < 60) it.op = OP_INVALIDATE;
      else if (r < 65) it.op = OP_PURGE;
      else if (r < 70) it.op = OP_WRITEBACK;
      else if (r < 75) it.op = OP_TAGREAD;
      else if (r < 81) it.op = OP_TAGWRITE;
      else if (r < 86) it.op = OP_DATAREAD;
      else if (r < 93) it.op = OP_DATAWRITE;
      else if (r < 95) it.op = OP_INVALL;
      else if (r < 97) it.op = OP_FILL;
      else it.op = 4'($urandom_range(OP_RSVD_LO, OP_RSVD_HI));
      if (it.op == OP_TAGWRITE && $urandom_range(0, 9) < 7)
         it.wd[28:10] = tag_pool[$urandom_range(0, 3)];
      slot = unknown_word(it);
      if (slot >= 0) begin
         it.op = OP_DATAWRITE;
         it.addr[13:2] = 12'(slot);
      end
      return it;
   endfunction

   task automatic send_item(input cache_item it);
      if (burst_left == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      req_if.op = it.op;
      req_if.address = it.addr;
      req_if.access_size = it.size;
      req_if.wdata = it.wd;
      req_if.valid = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      predict_cache(it);
      accepted++;
      burst_left--;
      @(negedge clock);
   endtask

   // result side: own stall pattern, one long hold-off
   initial begin
      int stall;
      bit steady;
      rsp_if.ready = 1'b0;
      stall = 0;
      steady = 0;
      forever begin
         @(negedge clock);
         if (long_hold_go) begin
            long_hold_go = 0;
            rsp_if.ready = 1'b0;
            for (int c = 0; c < 400; c++) @(negedge clock);
         end
         if ($urandom_range(0, 199) == 0) steady = !steady;
         if (stall > 0) begin
            stall--;
            rsp_if.ready = 1'b0;
         end else if (!steady && $urandom_range(0, 9) < 3) begin
            stall = $urandom_range(0, 5);
            rsp_if.ready = 1'b0;
         end else begin
            rsp_if.ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cache_result got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.kind = rsp_if.kind;
         got.bus = rsp_if.bus_address;
         got.rdata = rsp_if.rdata;
         got.last = rsp_if.last;
         results_seen++;
         if (expected_q.size() == 0) begin
            want = '{default: '0};
            report("unexpected item", got, want);
         end else begin
            want = expected_q.pop_front();
            if (got.kind !== want.kind) report("kind", got, want);
            else if (got.bus !== want.bus) report("bus_address", got, want);
            else if (got.rdata !== want.rdata) report("rdata", got, want);
            else if (got.last !== want.last) report("last", got, want);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      cache_item plan[$];
      req_if.valid = 1'b0;
      req_if.op = OP_READ;
      req_if.address = '0;
      req_if.access_size = '0;
      req_if.wdata = '0;
      fill_busy = 0;
      held_addr = '0; held_size = '0; held_op = '0; held_wd = '0; beats_in = '0;
      for (int k = 0; k < NUM_LINES; k++) begin
         line_tag[k] = '0; line_valid[k] = 0; line_dirty[k] = 0;
      end
      for (int k = 0; k < NUM_LINES*LINE_WORDS; k++) begin
         line_word[k] = '0; word_known[k] = 0;
      end
      for (int k = 0; k < 4; k++) tag_pool[k] = TAG_W'($urandom());
      tag_pool[0] = '1;
      idx_pool[0] = 9'd0;
      idx_pool[1] = 9'd511;
      for (int k = 2; k < 8; k++) idx_pool[k] = 9'($urandom());

      plan.push_back(row(OP_TAGREAD, 29'd0, 2'd2, 32'd0, 1, KIND_READ, 32'd0));
      plan.push_back(row(OP_FILL, 29'd0, 2'd2, 32'h1234, 1, KIND_REJECT, 32'd0));
      plan.push_back(row(OP_RSVD_LO, 29'd0, 2'd0, 32'd0, 1, KIND_REJECT, 32'd0));
      plan.push_back(row(OP_RSVD_HI, '1, 2'd3, '1, 1, KIND_REJECT, 32'd0));
      plan.push_back(row(OP_INVALIDATE, 29'd0, 2'd0, 32'd0, 1, KIND_DONE, 32'd0));
      plan.push_back(row(OP_PURGE, 29'd0, 2'd0, 32'd0, 1, KIND_DONE, 32'd0));
      plan.push_back(row(OP_WRITEBACK, 29'd0, 2'd0, 32'd0, 1, KIND_DONE, 32'd0));
      plan.push_back(row(OP_READ, 29'h1FFFFFFF, 2'd3, 32'd0));
      plan.push_back(row(OP_WRITE, 29'd0, 2'd2, 32'd5, 1, KIND_REJECT, 32'd0));
      plan.push_back(row(OP_FILL, 29'd0, 2'd0, 32'h00000000));
      plan.push_back(row(OP_FILL, 29'd0, 2'd0, 32'hFFFFFFFF));
      plan.push_back(row(OP_FILL, 29'd0, 2'd0, 32'h80000000));
      plan.push_back(row(OP_FILL, 29'd0, 2'd0, 32'h7FFFFFFF));
      plan.push_back(row(OP_FILL, 29'd0, 2'd0, 32'h00000080));
      plan.push_back(row(OP_FILL, 29'd0, 2'd0, 32'h00008000));
      plan.push_back(row(OP_FILL, 29'd0, 2'd0, 32'hA5A5A5A5));
      plan.push_back(row(OP_FILL, 29'd0, 2'd0, 32'h5A5A5A5A));
      plan.push_back(row(OP_READ, 29'h1FFFFFE4, 2'd0, 32'd0));
      plan.push_back(row(OP_READ, 29'h1FFFFFEB, 2'd1, 32'd0));
      plan.push_back(row(OP_WRITE, 29'h1FFFFFE0, 2'd0, 32'hFFFFFFFF));
      plan.push_back(row(OP_TAGREAD, 29'h1FFFFFE0, 2'd0, 32'd0));
      plan.push_back(row(OP_DATAWRITE, 29'd0, 2'd2, 32'hDEADBEEF, 1, KIND_DONE, 32'd0));
      plan.push_back(row(OP_DATAREAD, 29'd0, 2'd2, 32'd0, 1, KIND_READ, 32'hDEADBEEF));
      plan.push_back(row(OP_TAGWRITE, 29'h8, 2'd0, 32'hFFFFFFFF, 1, KIND_DONE, 32'd0));
      plan.push_back(row(OP_TAGWRITE, 29'h1FFFFFE0, 2'd0, 32'd0));
      plan.push_back(row(OP_INVALL, 29'd0, 2'd0, 32'd0, 1, KIND_DONE, 32'd0));
      plan.push_back(row(OP_PREFETCH, 29'd0, 2'd2, 32'd0));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) send_item(plan[i]);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 100) long_hold_go = 1;
         send_item(random_item());
      end
      req_if.valid = 1'b0;

      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d items (%0d directed) and %0d result items in %0d cycles,",
               accepted, plan.size(), results_seen, cycles);
      $display("with misses, fills, victim copy-back, maintenance and array access under stalls.");
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches", errors);
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
